// File: rtl/core/paxos_learner_quorum_tracker_defines.svh
// assertion macros for the paxos learner quorum tracker checker
// no dependencies; included by the checker file only
`ifndef PAXOS_LEARNER_QUORUM_TRACKER_DEFINES_SVH
`define PAXOS_LEARNER_QUORUM_TRACKER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PQT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pqt check failed");

// next-cycle implication, disabled during reset
`define PQT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pqt check failed");

`endif

// File: rtl/core/pqt_pkg.sv
// shared constants for the paxos learner quorum tracker
// beat layouts, status codes and parameter defaults; no dependencies
package pqt_pkg;

  localparam int DEF_MAX_ACCEPTORS = 8;
  localparam int DEF_BALLOT_BITS   = 32;

  localparam int          ACNT_W     = 4;
  localparam logic [3:0]  ACNT_RESET = 4'd3;

  // input beat: tuser = op, tdata = instance_id, acceptor_id, ballot, is_final
  localparam int IN_TDATA_W = 72;
  localparam int IN_IID_LSB = 0;
  localparam int IN_AID_LSB = 32;
  localparam int IN_BAL_LSB = 35;
  localparam int IN_FIN_BIT = 67;

  // output beat: tuser = status, tdata = closed, current_instance,
  // chosen_acceptor, chosen_ballot
  localparam int OUT_TDATA_W  = 72;
  localparam int OUT_CLS_BIT  = 0;
  localparam int OUT_INST_LSB = 1;
  localparam int OUT_CA_LSB   = 33;
  localparam int OUT_CB_LSB   = 36;
  localparam int OUT_CB_MSB   = 67;

  localparam logic [0:0] OP_ACK   = 1'b0;
  localparam logic [0:0] OP_CLEAR = 1'b1;

  localparam logic [1:0] STAT_STORED  = 2'd0;
  localparam logic [1:0] STAT_CLOSED  = 2'd1;
  localparam logic [1:0] STAT_STALE   = 2'd2;
  localparam logic [1:0] STAT_CLEARED = 2'd3;

endpackage

// File: rtl/core/pqt_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies; contents are not reset
module pqt_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/paxos_learner_quorum_tracker.sv
// paxos learner quorum tracker: top level with ack table and quorum scan
// depends on pqt_pkg and pqt_ram
//
// Usage:
//   in_* is the ack channel: in_tuser[0] is the op (ack or clear), in_tdata
//   carries instance id, acceptor index, ballot and final flag.
//   out_* returns one result beat per input beat: out_tuser is the status,
//   out_tdata holds closed flag, held instance, chosen acceptor and ballot.
//   cfg_wr_en / cfg_wr_data set the acceptor count; write only while idle.
// Sequence:
//   a clear goes from accept straight to loading the output register. an ack first
//   reads and updates the acceptor's table entry, then scans entries
//   0 .. min(acceptor_count, MAX_ACCEPTORS)-1 through the table ram read
//   port, one entry per cycle, each compared after its registered read,
//   then loads the output register. the scan is skipped when the instance
//   is closed or that minimum is zero, and stops early on a matching final
//   ack. a new beat is taken in the cycle after the result is loaded.
// Reset: table valid bits, instance, ballot and closed latch clear, the
//   acceptor count returns to 3. no clearing pass is needed.
// Stall: the result waits in the output register; the next input beat is
//   still accepted and processed, and waits at its last step until the
//   register frees.
module paxos_learner_quorum_tracker #(
  parameter int MAX_ACCEPTORS = pqt_pkg::DEF_MAX_ACCEPTORS,
  parameter int BALLOT_BITS   = pqt_pkg::DEF_BALLOT_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // instance_id[31:0], acceptor_id[34:32], ballot[66:35], is_final[67], zero pad
  input  logic [pqt_pkg::IN_TDATA_W-1:0]  in_tdata,
  // op[0]
  input  logic [0:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // closed[0], current_instance[32:1], chosen_acceptor[35:33],
  // chosen_ballot[67:36], zero pad
  output logic [pqt_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [1:0]                      out_tuser,
  input  logic                            cfg_wr_en,
  input  logic [pqt_pkg::ACNT_W-1:0]      cfg_wr_data
);

  localparam int AW = (MAX_ACCEPTORS > 1) ? $clog2(MAX_ACCEPTORS) : 1;
  localparam int CW = $clog2(MAX_ACCEPTORS + 1);
  localparam int LW = (CW > pqt_pkg::ACNT_W) ? CW : pqt_pkg::ACNT_W;
  localparam int RW = BALLOT_BITS + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  logic [pqt_pkg::ACNT_W-1:0]   acnt_r, acnt_nxt;
  logic [MAX_ACCEPTORS-1:0]     valid_r, valid_nxt;
  logic [31:0]                  held_r, held_nxt;
  logic [BALLOT_BITS-1:0]       last_r, last_nxt;
  logic                         closed_r, closed_nxt;
  logic [2:0]                   chosen_r, chosen_nxt;

  logic [2:0]                   aid_r, aid_nxt;
  logic [BALLOT_BITS-1:0]       bal_r, bal_nxt;
  logic                         fin_r, fin_nxt;
  logic [1:0]                   status_r, status_nxt;

  logic [AW-1:0]                iss_idx_r, iss_idx_nxt;
  logic                         iss_on_r, iss_on_nxt;
  logic [AW-1:0]                chk_idx_r, chk_idx_nxt;
  logic                         chk_on_r, chk_on_nxt;
  logic [AW-1:0]                lim_m1_r, lim_m1_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [AW-1:0]                pick_r, pick_nxt;

  logic                         out_tvalid_r, out_tvalid_nxt;
  logic [pqt_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [1:0]                   out_tuser_r, out_tuser_nxt;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [RW-1:0]                ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic [RW-1:0]                ram_rdata;
  logic [BALLOT_BITS-1:0]       rd_ballot;
  logic                         rd_final;

  logic                         in_fire;
  logic [2:0]                   in_aid;
  logic [LW-1:0]                acnt_ext;
  logic [LW-1:0]                max_ext;
  logic [LW-1:0]                limit;
  logic [pqt_pkg::ACNT_W-1:0]   need;
  logic [AW-1:0]                aid_a;
  logic                         aid_oob;
  logic                         match;
  logic [CW-1:0]                count_inc;

  pqt_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_ACCEPTORS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign rd_ballot = ram_rdata[BALLOT_BITS-1:0];
  assign rd_final  = ram_rdata[BALLOT_BITS];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_aid    = in_tdata[pqt_pkg::IN_AID_LSB +: 3];

  assign acnt_ext = LW'(acnt_r);
  assign max_ext  = LW'(MAX_ACCEPTORS);
  assign limit    = (acnt_ext < max_ext) ? acnt_ext : max_ext;
  assign need     = (acnt_r >> 1) + pqt_pkg::ACNT_W'(1);

  assign aid_a   = AW'(aid_r);
  assign aid_oob = ({4'b0, aid_r} >= 7'(MAX_ACCEPTORS));

  // scan compare on the entry read last cycle
  assign match     = chk_on_r && valid_r[chk_idx_r] && (rd_ballot == last_r);
  assign count_inc = count_r + CW'(match);

  assign ram_raddr = (state_r == S_IDLE) ? AW'(in_aid) : iss_idx_r;
  assign ram_waddr = aid_a;
  assign ram_wdata = {fin_r, bal_r};

  always_comb begin
    state_nxt      = state_r;
    acnt_nxt       = cfg_wr_en ? cfg_wr_data : acnt_r;
    valid_nxt      = valid_r;
    held_nxt       = held_r;
    last_nxt       = last_r;
    closed_nxt     = closed_r;
    chosen_nxt     = chosen_r;
    aid_nxt        = aid_r;
    bal_nxt        = bal_r;
    fin_nxt        = fin_r;
    status_nxt     = status_r;
    iss_idx_nxt    = iss_idx_r;
    iss_on_nxt     = iss_on_r;
    chk_idx_nxt    = chk_idx_r;
    chk_on_nxt     = chk_on_r;
    lim_m1_nxt     = lim_m1_r;
    count_nxt      = count_r;
    pick_nxt       = pick_r;
    ram_we         = 1'b0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          aid_nxt = in_aid;
          bal_nxt = BALLOT_BITS'(in_tdata[pqt_pkg::IN_BAL_LSB +: 32]);
          fin_nxt = in_tdata[pqt_pkg::IN_FIN_BIT];
          if (in_tuser == pqt_pkg::OP_CLEAR) begin
            valid_nxt  = '0;
            held_nxt   = '0;
            last_nxt   = '0;
            closed_nxt = 1'b0;
            chosen_nxt = '0;
            status_nxt = pqt_pkg::STAT_CLEARED;
            state_nxt  = S_EMIT;
          end else begin
            // first ack of an instance adopts its id and ballot
            if (held_r == '0) begin
              held_nxt = in_tdata[pqt_pkg::IN_IID_LSB +: 32];
              last_nxt = BALLOT_BITS'(in_tdata[pqt_pkg::IN_BAL_LSB +: 32]);
            end
            state_nxt = S_LOOK;
          end
        end
      end

      S_LOOK: begin
        if (closed_r) begin
          status_nxt = pqt_pkg::STAT_CLOSED;
        end else if (aid_oob || (valid_r[aid_a] && (rd_ballot >= bal_r))) begin
          status_nxt = pqt_pkg::STAT_STALE;
        end else begin
          ram_we           = 1'b1;
          valid_nxt[aid_a] = 1'b1;
          last_nxt         = bal_r;
          status_nxt       = pqt_pkg::STAT_STORED;
        end
        iss_idx_nxt = '0;
        iss_on_nxt  = 1'b1;
        chk_on_nxt  = 1'b0;
        count_nxt   = '0;
        pick_nxt    = '0;
        lim_m1_nxt  = AW'(limit - LW'(1));
        if (closed_r || (limit == '0)) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        // issue side: one table read per cycle
        if (iss_on_r) begin
          if (iss_idx_r == lim_m1_r) begin
            iss_on_nxt = 1'b0;
          end else begin
            iss_idx_nxt = iss_idx_r + AW'(1);
          end
        end
        chk_on_nxt  = iss_on_r;
        chk_idx_nxt = iss_idx_r;
        // check side: entry issued last cycle
        if (chk_on_r) begin
          count_nxt = count_inc;
          if (match) begin
            pick_nxt = chk_idx_r;
          end
          if (match && rd_final) begin
            closed_nxt = 1'b1;
            chosen_nxt = 3'(chk_idx_r);
            state_nxt  = S_EMIT;
          end else if (chk_idx_r == lim_m1_r) begin
            if (LW'(count_inc) >= LW'(need)) begin
              closed_nxt = 1'b1;
              chosen_nxt = match ? 3'(chk_idx_r) : 3'(pick_r);
            end
            state_nxt = S_EMIT;
          end
        end
      end

      S_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = status_r;
          out_tdata_nxt  = '0;
          out_tdata_nxt[pqt_pkg::OUT_CLS_BIT]       = closed_r;
          out_tdata_nxt[pqt_pkg::OUT_INST_LSB +: 32] = held_r;
          out_tdata_nxt[pqt_pkg::OUT_CA_LSB +: 3]   = closed_r ? chosen_r : 3'd0;
          out_tdata_nxt[pqt_pkg::OUT_CB_LSB +: 32]  = closed_r ? 32'(last_r) : 32'd0;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      acnt_r       <= pqt_pkg::ACNT_RESET;
      valid_r      <= '0;
      held_r       <= '0;
      last_r       <= '0;
      closed_r     <= 1'b0;
      chosen_r     <= '0;
      iss_on_r     <= 1'b0;
      chk_on_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      acnt_r       <= acnt_nxt;
      valid_r      <= valid_nxt;
      held_r       <= held_nxt;
      last_r       <= last_nxt;
      closed_r     <= closed_nxt;
      chosen_r     <= chosen_nxt;
      iss_on_r     <= iss_on_nxt;
      chk_on_r     <= chk_on_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    aid_r       <= aid_nxt;
    bal_r       <= bal_nxt;
    fin_r       <= fin_nxt;
    status_r    <= status_nxt;
    iss_idx_r   <= iss_idx_nxt;
    chk_idx_r   <= chk_idx_nxt;
    lim_m1_r    <= lim_m1_nxt;
    count_r     <= count_nxt;
    pick_r      <= pick_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// File: rtl/core/pqt_checker.sv
// port-level checker for the paxos learner quorum tracker, bound to the top
// depends on pqt_pkg and paxos_learner_quorum_tracker_defines.svh
`include "paxos_learner_quorum_tracker_defines.svh"

module pqt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pqt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [1:0]                      out_tuser
);

  // a stalled result beat holds
  `PQT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // one item at a time: busy right after an accepted beat
  `PQT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // a clear result carries nothing but its status
  `PQT_ASSERT_NOW(a_clear_zero, clk, rst_n, out_tvalid && (out_tuser == pqt_pkg::STAT_CLEARED), out_tdata == '0)

  // chosen fields only show on a closed instance
  `PQT_ASSERT_NOW(a_open_no_choice, clk, rst_n, out_tvalid && !out_tdata[pqt_pkg::OUT_CLS_BIT], out_tdata[pqt_pkg::OUT_CB_MSB:pqt_pkg::OUT_CA_LSB] == '0)

  // dropped as closed means the instance reads closed
  `PQT_ASSERT_NOW(a_drop_closed, clk, rst_n, out_tvalid && (out_tuser == pqt_pkg::STAT_CLOSED), out_tdata[pqt_pkg::OUT_CLS_BIT])

endmodule

bind paxos_learner_quorum_tracker pqt_checker u_pqt_checker (.*);

// File: dv/tb_paxos_learner_quorum_tracker.sv
// testbench for the paxos learner quorum tracker: directed acks, quorum rounds and noise
// checked beat by beat against an in-bench learner predictor; depends on pqt_pkg and the rtl
`timescale 1ns / 1ps

module tb_paxos_learner_quorum_tracker;

  localparam int NUM_SLOTS   = pqt_pkg::DEF_MAX_ACCEPTORS;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 24;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [0:0]  op;
    logic [31:0] iid;
    logic [2:0]  aid;
    logic [31:0] bal;
    logic        fin;
  } ack_beat_t;

  typedef struct {
    logic [1:0]  status;
    logic        closed;
    logic [31:0] inst;
    logic [2:0]  chosen_acc;
    logic [31:0] chosen_bal;
  } learner_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [pqt_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic [0:0]                      in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [pqt_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]                      out_tuser;
  logic                            cfg_wr_en = 1'b0;
  logic [pqt_pkg::ACNT_W-1:0]      cfg_wr_data = '0;

  paxos_learner_quorum_tracker uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  // learner predictor state
  bit          slot_valid [NUM_SLOTS];
  logic [31:0] slot_ballot[NUM_SLOTS];
  bit          slot_final [NUM_SLOTS];
  logic [31:0] held_inst;
  logic [31:0] last_bal;
  bit          closed_q;
  logic [2:0]  chosen_q;
  logic [3:0]  acc_count;

  learner_result_t pending_results[$];
  int errors = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int closes_seen = 0;
  int settings_used = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic void clear_learner();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_valid[i] = 1'b0;
      slot_ballot[i] = '0;
      slot_final[i] = 1'b0;
    end
    held_inst = '0;
    last_bal = '0;
    closed_q = 1'b0;
    chosen_q = '0;
  endfunction

  function automatic learner_result_t learn_beat(ack_beat_t b);
    learner_result_t r;
    int lim;
    int cnt;
    int pick;
    bit fin_seen;
    r.status = pqt_pkg::STAT_CLEARED;
    r.closed = 1'b0;
    r.inst = '0;
    r.chosen_acc = '0;
    r.chosen_bal = '0;
    if (b.op == pqt_pkg::OP_CLEAR) begin
      clear_learner();
      return r;
    end
    // first ack while no instance is held adopts its id and ballot
    if (held_inst == '0) begin
      held_inst = b.iid;
      last_bal = b.bal;
    end
    if (closed_q) begin
      r.status = pqt_pkg::STAT_CLOSED;
    end else if (slot_valid[b.aid] && slot_ballot[b.aid] >= b.bal) begin
      r.status = pqt_pkg::STAT_STALE;
    end else begin
      slot_valid[b.aid] = 1'b1;
      slot_ballot[b.aid] = b.bal;
      slot_final[b.aid] = b.fin;
      last_bal = b.bal;
      r.status = pqt_pkg::STAT_STORED;
    end
    if (!closed_q) begin
      lim = (acc_count > NUM_SLOTS) ? NUM_SLOTS : int'(acc_count);
      cnt = 0;
      pick = 0;
      fin_seen = 1'b0;
      for (int i = 0; i < lim && !fin_seen; i++) begin
        if (slot_valid[i] && slot_ballot[i] == last_bal) begin
          cnt++;
          pick = i;
          if (slot_final[i]) fin_seen = 1'b1;
        end
      end
      if (fin_seen || cnt >= int'(acc_count) / 2 + 1) begin
        closed_q = 1'b1;
        chosen_q = pick[2:0];
      end
    end
    r.closed = closed_q;
    r.inst = held_inst;
    r.chosen_acc = closed_q ? chosen_q : 3'd0;
    r.chosen_bal = closed_q ? last_bal : 32'd0;
    return r;
  endfunction

  function automatic ack_beat_t make_beat(logic [0:0] op, logic [31:0] iid, logic [2:0] aid,
                                          logic [31:0] bal, logic fin);
    ack_beat_t b;
    b.op = op;
    b.iid = iid;
    b.aid = aid;
    b.bal = bal;
    b.fin = fin;
    return b;
  endfunction

  // holds valid high across back-to-back beats, lowers it only for idle cycles
  task automatic send_beat(ack_beat_t b);
    logic [pqt_pkg::IN_TDATA_W-1:0] d;
    d = '0;
    d[pqt_pkg::IN_IID_LSB +: 32] = b.iid;
    d[pqt_pkg::IN_AID_LSB +: 3] = b.aid;
    d[pqt_pkg::IN_BAL_LSB +: 32] = b.bal;
    d[pqt_pkg::IN_FIN_BIT] = b.fin;
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= b.op;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(learn_beat(b));
    beats_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_acceptor_count(logic [3:0] n);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= n;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    acc_count = n;
    settings_used++;
  endtask

  task automatic set_idle(idle_mode_t m);
    send_idle_pct = (m == IDLE_SEND) ? 53 : (m == IDLE_BOTH) ? 8 : 0;
    recv_stall_pct = (m == IDLE_RECV) ? 53 : (m == IDLE_BOTH) ? 8 : 0;
  endtask

  // extremes of each field, clear, instance id zero and the acceptor count corners
  task automatic test_directed();
    send_beat(make_beat(pqt_pkg::OP_ACK, 32'd0, 3'd0, 32'd5, 1'b0));
    send_beat(make_beat(pqt_pkg::OP_ACK, 32'hFFFF_FFFF, 3'd1, 32'd5, 1'b0));
    send_beat(make_beat(pqt_pkg::OP_ACK, 32'd9, 3'd2, 32'd6, 1'b0));
    send_beat(make_beat(pqt_pkg::OP_CLEAR, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF, 1'b1));
    // acceptor beyond the count is stored but not scanned
    send_beat(make_beat(pqt_pkg::OP_ACK, 32'd7, 3'd7, 32'hFFFF_FFFF, 1'b1));
    send_beat(make_beat(pqt_pkg::OP_ACK, 32'd7, 3'd7, 32'hFFFF_FFFF, 1'b0));
    send_beat(make_beat(pqt_pkg::OP_ACK, 32'd7, 3'd7, 32'd0, 1'b0));
    send_beat(make_beat(pqt_pkg::OP_ACK, 32'd7, 3'd0, 32'd0, 1'b1));
    send_beat(make_beat(pqt_pkg::OP_CLEAR, 32'd0, 3'd0, 32'd0, 1'b0));
    send_beat(make_beat(pqt_pkg::OP_ACK, 32'd1, 3'd2, 32'hFFFF_FFFF, 1'b1));
    send_beat(make_beat(pqt_pkg::OP_CLEAR, 32'd0, 3'd0, 32'd0, 1'b0));
    // zero acceptors never closes, even on a final ack
    set_acceptor_count(4'd0);
    send_beat(make_beat(pqt_pkg::OP_ACK, 32'h5555_AAAA, 3'd0, 32'd9, 1'b1));
    send_beat(make_beat(pqt_pkg::OP_ACK, 32'hAAAA_5555, 3'd1, 32'd9, 1'b1));
    // count above the table size scans all eight slots, quorum stays count/2+1
    set_acceptor_count(4'd15);
    send_beat(make_beat(pqt_pkg::OP_CLEAR, 32'd0, 3'd0, 32'd0, 1'b0));
    for (int i = 0; i < NUM_SLOTS; i++)
      send_beat(make_beat(pqt_pkg::OP_ACK, 32'd3, i[2:0], 32'd3, 1'b0));
    set_acceptor_count(4'd1);
    send_beat(make_beat(pqt_pkg::OP_CLEAR, 32'd0, 3'd0, 32'd0, 1'b0));
    send_beat(make_beat(pqt_pkg::OP_ACK, 32'd0, 3'd0, 32'd0, 1'b0));
  endtask

  // usually a clear, then a burst of acks around one ballot so quorums and finals get reached
  task automatic test_quorum_rounds(int n_beats);
    int sent;
    int lim;
    int len;
    logic [31:0] base;
    logic [31:0] bal;
    logic [31:0] iid;
    logic [2:0] aid;
    sent = 0;
    lim = (acc_count > NUM_SLOTS) ? NUM_SLOTS : int'(acc_count);
    while (sent < n_beats) begin
      if ($urandom_range(7) != 0) begin
        send_beat(make_beat(pqt_pkg::OP_CLEAR, $urandom(), 3'($urandom_range(7)), $urandom(),
                            1'($urandom_range(1))));
        sent++;
      end
      base = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(1, 6);
      len = $urandom_range(1, lim + 2);
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(9))
          0: bal = base + 1;
          1: bal = base - 1;
          2: bal = $urandom();
          default: bal = base;
        endcase
        aid = (lim > 0 && $urandom_range(9) != 0) ? 3'($urandom_range(lim - 1)) :
                                                    3'($urandom_range(7));
        iid = ($urandom_range(19) == 0) ? 32'd0 : $urandom();
        send_beat(make_beat(pqt_pkg::OP_ACK, iid, aid, bal, $urandom_range(9) == 0));
        sent++;
      end
    end
  endtask

  task automatic test_random_noise(int n_beats);
    logic [31:0] bal;
    for (int k = 0; k < n_beats; k++) begin
      bal = $urandom_range(1) ? $urandom() : $urandom_range(7);
      send_beat(make_beat(($urandom_range(11) == 0) ? pqt_pkg::OP_CLEAR : pqt_pkg::OP_ACK,
                          $urandom(), 3'($urandom_range(7)), bal, 1'($urandom_range(1))));
    end
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    learner_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation waiting: tuser %0d tdata %h", out_tuser,
               out_tdata);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (e.closed && e.status != pqt_pkg::STAT_CLEARED) closes_seen++;
        if (out_tuser !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_tuser);
          errors++;
        end
        if (out_tdata[pqt_pkg::OUT_CLS_BIT] !== e.closed) begin
          $error("closed: expected %0d, got %0d", e.closed, out_tdata[pqt_pkg::OUT_CLS_BIT]);
          errors++;
        end
        if (out_tdata[pqt_pkg::OUT_INST_LSB +: 32] !== e.inst) begin
          $error("current_instance: expected %h, got %h", e.inst,
                 out_tdata[pqt_pkg::OUT_INST_LSB +: 32]);
          errors++;
        end
        if (out_tdata[pqt_pkg::OUT_CA_LSB +: 3] !== e.chosen_acc) begin
          $error("chosen_acceptor: expected %0d, got %0d", e.chosen_acc,
                 out_tdata[pqt_pkg::OUT_CA_LSB +: 3]);
          errors++;
        end
        if (out_tdata[pqt_pkg::OUT_CB_MSB:pqt_pkg::OUT_CB_LSB] !== e.chosen_bal) begin
          $error("chosen_ballot: expected %h, got %h", e.chosen_bal,
                 out_tdata[pqt_pkg::OUT_CB_MSB:pqt_pkg::OUT_CB_LSB]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [3:0] counts[8];
    counts = '{4'd8, 4'd0, 4'd15, 4'd1, 4'd5, 4'd3, 4'd2, 4'd7};
    clear_learner();
    acc_count = pqt_pkg::ACNT_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idle(IDLE_NONE);
    test_directed();

    for (int p = 0; p < 8; p++) begin
      set_acceptor_count(counts[p]);
      set_idle(idle_mode_t'(p % 4));
      test_quorum_rounds(62);
      test_random_noise(28);
    end

    drain();
    $display("sent %0d beats across %0d acceptor-count writes and four idle patterns",
             beats_sent, settings_used);
    $display("checked %0d result beats, %0d of them with the instance closed",
             results_seen, closes_seen);
    if (errors == 0 && pending_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
